// ===== rtl/pse_pkg.sv =====
// Shared types and constants for the printable string extractor.
package pse_pkg;

    localparam int MIN_LEN_DEFAULT = 4;

    localparam int CODE_W   = 16;
    localparam int ADDR_W   = 64;
    localparam int PID_W    = 32;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CHAR_MODE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_ID = 1'd1;

    // Result kinds
    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Printable character bounds
    localparam logic [CODE_W-1:0] PRINT_LO = 16'h0020;
    localparam logic [CODE_W-1:0] PRINT_HI = 16'h007E;
    localparam logic [CODE_W-1:0] CHAR_TAB = 16'h0009;
    localparam logic [CODE_W-1:0] CHAR_LF  = 16'h000A;
    localparam logic [CODE_W-1:0] CHAR_CR  = 16'h000D;

    // Results caused by one item: optional release of the held characters,
    // optional current character, optional end marker, in that order.
    typedef struct packed {
        logic              rel;
        logic              has_char;
        logic              has_end;
        logic [CODE_W-1:0] chr;
        logic [ADDR_W-1:0] addr;
    } burst_t;

endpackage

// ===== rtl/pse_scan.sv =====
// Run tracking: classifies each code unit and updates run state.
module pse_scan #(
    parameter int MIN_LEN = pse_pkg::MIN_LEN_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        char_mode,
    input  logic [pse_pkg::CODE_W-1:0]  code,
    input  logic [pse_pkg::ADDR_W-1:0]  addr,
    input  logic                        sect_end,
    input  logic                        take,
    output logic                        produces,
    output pse_pkg::burst_t             burst,
    output logic [pse_pkg::CODE_W-1:0]  held_snap [MIN_LEN-1]
);
    import pse_pkg::*;

    localparam int RL_W = $clog2(MIN_LEN + 1);
    localparam logic [RL_W-1:0] RL_HOLD = RL_W'(MIN_LEN - 1);
    localparam logic [RL_W-1:0] RL_FULL = RL_W'(MIN_LEN);

    logic [RL_W-1:0]   run_len_reg, run_len_next;
    logic [ADDR_W-1:0] run_start_reg, run_start_next;
    logic [CODE_W-1:0] held_reg [MIN_LEN-1];
    logic [CODE_W-1:0] held_next [MIN_LEN-1];

    logic [CODE_W-1:0] c;
    logic              printable;

    always_comb
    begin
        c = char_mode ? code : {8'h00, code[7:0]};
        printable = (c >= PRINT_LO && c <= PRINT_HI) || c == CHAR_TAB || c == CHAR_LF
                    || (!char_mode && c == CHAR_CR);

        run_len_next   = run_len_reg;
        run_start_next = run_start_reg;
        held_next      = held_reg;
        burst.rel      = 1'b0;
        burst.has_char = 1'b0;
        burst.has_end  = 1'b0;
        burst.chr      = c;

        if (printable)
        begin
            if (run_len_reg == '0)
                run_start_next = addr;
            if (run_len_reg < RL_HOLD)
            begin
                // shift in, oldest character stays at entry zero
                for (int i = 0; i < MIN_LEN - 2; i++)
                    held_next[i] = held_reg[i+1];
                held_next[MIN_LEN-2] = c;
                run_len_next = run_len_reg + 1'b1;
            end
            else if (run_len_reg == RL_HOLD)
            begin
                burst.rel      = 1'b1;
                burst.has_char = 1'b1;
                run_len_next   = RL_FULL;
            end
            else
            begin
                burst.has_char = 1'b1;
            end
        end
        else
        begin
            burst.has_end = (run_len_reg >= RL_FULL);
            run_len_next  = '0;
        end

        // close the run after the last unit of a section
        if (sect_end)
        begin
            if (run_len_next >= RL_FULL)
                burst.has_end = 1'b1;
            run_len_next = '0;
        end

        burst.addr = run_start_next;
        produces   = burst.rel | burst.has_char | burst.has_end;
        held_snap  = held_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_len_reg   <= '0;
            run_start_reg <= '0;
        end
        else if (take)
        begin
            run_len_reg   <= run_len_next;
            run_start_reg <= run_start_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            held_reg <= held_next;
    end

endmodule

// ===== rtl/pse_emit.sv =====
// Result sequencer: holds one burst and hands out its results one per cycle while out_ready is high.
module pse_emit #(
    parameter int MIN_LEN = pse_pkg::MIN_LEN_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  pse_pkg::burst_t             burst,
    input  logic [pse_pkg::CODE_W-1:0]  held_snap [MIN_LEN-1],
    output logic                        burst_ready,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        kind,
    output logic [pse_pkg::CODE_W-1:0]  char_value,
    output logic [pse_pkg::ADDR_W-1:0]  string_addr,
    output logic                        burst_last
);
    import pse_pkg::*;

    localparam int REM_W = $clog2(MIN_LEN);

    logic              bvalid_reg;
    logic [REM_W-1:0]  rem_reg;
    logic              has_char_reg;
    logic              has_end_reg;
    logic [CODE_W-1:0] chr_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [CODE_W-1:0] snap_reg [MIN_LEN-1];

    logic out_take;

    always_comb
    begin
        out_valid   = bvalid_reg;
        burst_last  = (rem_reg == '0) && !(has_char_reg && has_end_reg);
        out_take    = bvalid_reg && out_ready;
        burst_ready = !bvalid_reg || (out_ready && burst_last);
        string_addr = addr_reg;
        if (rem_reg != '0)
        begin
            kind       = KIND_CHAR;
            char_value = snap_reg[0];
        end
        else if (has_char_reg)
        begin
            kind       = KIND_CHAR;
            char_value = chr_reg;
        end
        else
        begin
            kind       = KIND_END;
            char_value = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bvalid_reg   <= 1'b0;
            rem_reg      <= '0;
            has_char_reg <= 1'b0;
            has_end_reg  <= 1'b0;
        end
        else if (load)
        begin
            bvalid_reg   <= 1'b1;
            rem_reg      <= burst.rel ? REM_W'(MIN_LEN - 1) : '0;
            has_char_reg <= burst.has_char;
            has_end_reg  <= burst.has_end;
        end
        else if (out_take)
        begin
            if (burst_last)
                bvalid_reg <= 1'b0;
            else if (rem_reg != '0)
                rem_reg <= rem_reg - 1'b1;
            else
                has_char_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            chr_reg  <= burst.chr;
            addr_reg <= burst.addr;
            snap_reg <= held_snap;
        end
        else if (out_take && rem_reg != '0)
        begin
            // advance to the next held character
            for (int i = 0; i < MIN_LEN - 2; i++)
                snap_reg[i] <= snap_reg[i+1];
        end
    end

endmodule

// ===== rtl/printable_string_extractor.sv =====
// Top level of the printable string extractor.
//
// Input channel (in_valid/in_ready) takes one code unit per item with its
// address and a section_end flag; output channel (out_valid/out_ready)
// gives one result per item: a string character (kind 0) or an end marker
// (kind 1). burst_last flags the final result caused by one input item.
// Configuration: cfg_wr_en writes cfg_wdata to register cfg_index
// (0: char_mode, 1: process_id); write only while the block is idle.
// An item is registered in the input register when accepted; its first
// result is registered in the output sequencer once it can take the burst.
// Throughput: one item per cycle while each item causes at most one result
// and out_ready is high. An item that completes a run of MIN_LEN characters
// causes MIN_LEN results (MIN_LEN+1 at a section end), given one per cycle
// while out_ready is high; the next burst is held until these have left.
// Reset clears the run state, both configuration registers and both valid
// flags. A stalled receiver holds the current result; the input register
// still takes one item, and items that cause no result keep flowing.
module printable_string_extractor #(
    parameter int MIN_LEN = pse_pkg::MIN_LEN_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [pse_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pse_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [pse_pkg::CODE_W-1:0]    code_unit,
    input  logic [pse_pkg::ADDR_W-1:0]    unit_addr,
    input  logic                          section_end,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          kind,
    output logic [pse_pkg::CODE_W-1:0]    char_value,
    output logic [pse_pkg::ADDR_W-1:0]    string_addr,
    output logic [pse_pkg::PID_W-1:0]     owner_pid,
    output logic                          burst_last
);
    import pse_pkg::*;

    logic              char_mode_reg;
    logic [PID_W-1:0]  pid_reg;

    logic              in_vld_reg;
    logic [CODE_W-1:0] code_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic              end_reg;

    logic              produces;
    logic              burst_ready;
    logic              scan_take;
    logic              burst_load;
    burst_t            burst;
    logic [CODE_W-1:0] held_snap [MIN_LEN-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_mode_reg <= 1'b0;
            pid_reg       <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_CHAR_MODE:  char_mode_reg <= cfg_wdata[0];
                CFG_PROCESS_ID: pid_reg       <= cfg_wdata[PID_W-1:0];
                default: ;
            endcase
        end
    end

    // an item with results waits until the sequencer can take its burst
    assign scan_take  = in_vld_reg && (!produces || burst_ready);
    assign burst_load = scan_take && produces;
    assign in_ready   = !in_vld_reg || scan_take;
    assign owner_pid  = pid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (in_ready)
            in_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            code_reg <= code_unit;
            addr_reg <= unit_addr;
            end_reg  <= section_end;
        end
    end

    pse_scan #(
        .MIN_LEN (MIN_LEN)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_mode (char_mode_reg),
        .code      (code_reg),
        .addr      (addr_reg),
        .sect_end  (end_reg),
        .take      (scan_take),
        .produces  (produces),
        .burst     (burst),
        .held_snap (held_snap)
    );

    pse_emit #(
        .MIN_LEN (MIN_LEN)
    ) u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (burst_load),
        .burst       (burst),
        .held_snap   (held_snap),
        .burst_ready (burst_ready),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .char_value  (char_value),
        .string_addr (string_addr),
        .burst_last  (burst_last)
    );

    a_end_marker: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_END |-> char_value == '0 && burst_last)
        else $error("end marker with character or not last in burst");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        !in_vld_reg && !out_valid |=> !out_valid)
        else $error("result appeared without an item");

    a_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg && !scan_take |=> in_vld_reg && $stable(code_reg))
        else $error("pending item lost");

endmodule
